[sv/twspi_pkg.sv]
// Shared types and constants for the three-wire 9-bit serial panel master.
package twspi_pkg;

   // Command codes carried in the mode field.
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_TICK_ALT = 2'd3;

   // Register addresses that select a longer read.
   localparam logic [7:0] ADDR_READ_24   = 8'h04;
   localparam logic [7:0] ADDR_READ_32   = 8'h09;
   localparam logic [7:0] ADDR_READ_GRAM = 8'h2e;

   // Reset value of the phase length register.
   localparam logic [7:0] TICKS_PER_PHASE_RESET = 8'h01;

   // Register word indexes on the configuration port.
   localparam logic REG_TICKS_PER_PHASE = 1'b0;

   // Pin level bits: select, clock, data.
   localparam int PIN_CS  = 2;
   localparam int PIN_CLK = 1;
   localparam int PIN_SDO = 0;
   localparam logic [2:0] PINS_IDLE = 3'b100;

   typedef enum logic [4:0] {
      S_IDLE   = 5'd0,
      W_SETUP  = 5'd1,
      W_SEL    = 5'd2,
      W_FLAG   = 5'd3,
      W_FLAGHI = 5'd4,
      W_BLO    = 5'd5,
      W_BHI    = 5'd6,
      W_S1LO   = 5'd7,
      W_S1HI   = 5'd8,
      W_S2LO   = 5'd9,
      W_S2HI   = 5'd10,
      R_SETUP  = 5'd11,
      R_SEL    = 5'd12,
      R_FLAG   = 5'd13,
      R_FLAGHI = 5'd14,
      R_ALO    = 5'd15,
      R_AHI    = 5'd16,
      R_DUMLO  = 5'd17,
      R_DUMHI  = 5'd18,
      R_DLO    = 5'd19,
      R_DHI    = 5'd20,
      R_FRLO   = 5'd21,
      R_FRHI   = 5'd22,
      R_TAIL   = 5'd23,
      R_DESEL  = 5'd24
   } seq_step_type;

   typedef enum logic [1:0] {
      FMT_8    = 2'd0,
      FMT_24   = 2'd1,
      FMT_32   = 2'd2,
      FMT_GRAM = 2'd3
   } read_format_type;

   // One command or tick transaction.
   typedef struct packed {
      logic [1:0] mode;
      logic       dc_flag;
      logic [7:0] byte_value;
      logic       sdi;
   } req_item_type;

   // One result transaction.
   typedef struct packed {
      logic        cs_n;
      logic        sclk;
      logic        sdo;
      logic        busy_res;
      logic        done_res;
      logic [31:0] read_data;
   } rsp_item_type;

endpackage

[sv/twspi_if.sv]
// Valid/ready channel interfaces for command and result transactions.
interface twspi_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       dc_flag;
   logic [7:0] byte_value;
   logic       sdi;

   modport source (output valid, mode, dc_flag, byte_value, sdi, input ready);
   modport sink (input valid, mode, dc_flag, byte_value, sdi, output ready);
endinterface

interface twspi_rsp_if;
   logic        valid;
   logic        ready;
   logic        cs_n;
   logic        sclk;
   logic        sdo;
   logic        busy_res;
   logic        done_res;
   logic [31:0] read_data;

   modport source (output valid, cs_n, sclk, sdo, busy_res, done_res, read_data,
                   input ready);
   modport sink (input valid, cs_n, sclk, sdo, busy_res, done_res, read_data,
                 output ready);
endinterface

[sv/twspi_csr.sv]
// APB-style configuration register block holding the phase length.
module twspi_csr
   import twspi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  ticks_per_phase
);

   logic [7:0] ticks_ff;
   logic [7:0] ticks_in;
   logic       write_hit;

   // Only word zero holds a register; writes elsewhere are dropped.
   assign write_hit = psel && penable && pwrite && (paddr[2] == REG_TICKS_PER_PHASE);

   always_comb begin
      ticks_in = ticks_ff;
      if (write_hit) begin
         ticks_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TICKS_PER_PHASE_RESET;
      end else begin
         ticks_ff <= ticks_in;
      end
   end

   assign pready          = 1'b1;
   assign prdata          = (paddr[2] == REG_TICKS_PER_PHASE) ? {24'd0, ticks_ff} : 32'd0;
   assign ticks_per_phase = ticks_ff;

endmodule

[sv/twspi_seq.sv]
// Pin sequencer: state registers and the single-pass next-state logic.
module twspi_seq
   import twspi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   input  logic [7:0]   ticks_per_phase,
   output rsp_item_type result
);

   seq_step_type    step_ff, step_in;
   logic [5:0]      bit_count_ff, bit_count_in;
   logic [7:0]      phase_count_ff, phase_count_in;
   logic [7:0]      out_shift_ff, out_shift_in;
   logic [31:0]     read_accum_ff, read_accum_in;
   read_format_type format_ff, format_in;
   logic [2:0]      pins_ff, pins_in;

   logic [7:0]      span;
   logic [7:0]      phase_next;
   logic [5:0]      bit_dec;
   logic            do_enter;
   logic            done;

   assign span       = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
   assign phase_next = phase_count_ff + 8'd1;
   assign bit_dec    = bit_count_ff - 6'd1;

   // Next state for one transaction, then pin levels of the entered phase.
   always_comb begin
      step_in        = step_ff;
      bit_count_in   = bit_count_ff;
      phase_count_in = phase_count_ff;
      out_shift_in   = out_shift_ff;
      read_accum_in  = read_accum_ff;
      format_in      = format_ff;
      pins_in        = pins_ff;
      do_enter       = 1'b0;
      done           = 1'b0;

      if (step_ff == S_IDLE) begin
         if (item.mode == MODE_WRITE) begin
            out_shift_in   = item.byte_value;
            bit_count_in   = {5'd0, item.dc_flag};
            phase_count_in = 8'd0;
            step_in        = W_SETUP;
            do_enter       = 1'b1;
         end else if (item.mode == MODE_READ) begin
            out_shift_in   = item.byte_value;
            bit_count_in   = 6'd0;
            phase_count_in = 8'd0;
            read_accum_in  = 32'd0;
            case (item.byte_value)
               ADDR_READ_24:   format_in = FMT_24;
               ADDR_READ_32:   format_in = FMT_32;
               ADDR_READ_GRAM: format_in = FMT_GRAM;
               default:        format_in = FMT_8;
            endcase
            step_in  = R_SETUP;
            do_enter = 1'b1;
         end
      end else if (item.mode inside {MODE_TICK, MODE_TICK_ALT}) begin
         if (phase_next >= span) begin
            // Phase is over: pick the next phase.
            phase_count_in = 8'd0;
            do_enter       = 1'b1;
            case (step_ff)
               W_SETUP:  step_in = W_SEL;
               W_SEL:    step_in = W_FLAG;
               W_FLAG:   step_in = W_FLAGHI;
               W_FLAGHI: begin
                  bit_count_in = 6'd8;
                  step_in      = W_BLO;
               end
               W_BLO:    step_in = W_BHI;
               W_BHI: begin
                  out_shift_in = {out_shift_ff[6:0], 1'b0};
                  bit_count_in = bit_dec;
                  step_in      = (bit_dec != 6'd0) ? W_BLO : W_S1LO;
               end
               W_S1LO:   step_in = W_S1HI;
               W_S1HI:   step_in = W_S2LO;
               W_S2LO:   step_in = W_S2HI;
               R_SETUP:  step_in = R_SEL;
               R_SEL:    step_in = R_FLAG;
               R_FLAG:   step_in = R_FLAGHI;
               R_FLAGHI: begin
                  bit_count_in = 6'd8;
                  step_in      = R_ALO;
               end
               R_ALO:    step_in = R_AHI;
               R_AHI: begin
                  out_shift_in = {out_shift_ff[6:0], 1'b0};
                  bit_count_in = bit_dec;
                  if (bit_dec != 6'd0) begin
                     step_in = R_ALO;
                  end else begin
                     case (format_ff)
                        FMT_24: begin
                           bit_count_in = 6'd24;
                           step_in      = R_DUMLO;
                        end
                        FMT_32: begin
                           bit_count_in = 6'd32;
                           step_in      = R_DUMLO;
                        end
                        FMT_GRAM: begin
                           bit_count_in = 6'd24;
                           step_in      = R_FRLO;
                        end
                        default: begin
                           bit_count_in = 6'd8;
                           step_in      = R_DLO;
                        end
                     endcase
                  end
               end
               R_DUMLO:  step_in = R_DUMHI;
               R_DUMHI:  step_in = R_DLO;
               R_DLO: begin
                  read_accum_in = {read_accum_ff[30:0], item.sdi};
                  if (format_ff == FMT_GRAM) begin
                     read_accum_in[31:16] = 16'd0;
                  end
                  step_in = R_DHI;
               end
               R_DHI: begin
                  bit_count_in = bit_dec;
                  if (bit_dec == 6'd0) begin
                     step_in = R_TAIL;
                  end else if (format_ff == FMT_GRAM && bit_dec[2:0] == 3'd0) begin
                     step_in = R_FRLO;
                  end else begin
                     step_in = R_DLO;
                  end
               end
               R_FRLO:   step_in = R_FRHI;
               R_FRHI:   step_in = R_DLO;
               R_TAIL:   step_in = R_DESEL;
               default: begin
                  // Final stop or deselect phase ended: the transfer is done.
                  step_in  = S_IDLE;
                  do_enter = 1'b0;
                  done     = 1'b1;
               end
            endcase
         end else begin
            phase_count_in = phase_next;
         end
      end

      // Pin levels applied at the start of the entered phase.
      if (do_enter) begin
         case (step_in)
            W_SETUP, R_SETUP: pins_in = PINS_IDLE;
            W_SEL, R_SEL:     pins_in[PIN_CS] = 1'b0;
            W_FLAG:           pins_in[PIN_SDO] = bit_count_in[0];
            R_FLAG:           pins_in[PIN_SDO] = 1'b0;
            W_BLO, R_ALO: begin
               pins_in[PIN_CLK] = 1'b0;
               pins_in[PIN_SDO] = out_shift_in[7];
            end
            W_S1LO: begin
               pins_in[PIN_CS]  = 1'b1;
               pins_in[PIN_CLK] = 1'b0;
            end
            W_S2LO, R_DUMLO, R_DLO, R_TAIL: pins_in[PIN_CLK] = 1'b0;
            R_FRLO: begin
               pins_in[PIN_CLK] = 1'b0;
               pins_in[PIN_SDO] = 1'b0;
            end
            R_DESEL:          pins_in[PIN_CS] = 1'b1;
            default:          pins_in[PIN_CLK] = 1'b1;
         endcase
      end
   end

   // State registers advance once per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= S_IDLE;
         bit_count_ff   <= 6'd0;
         phase_count_ff <= 8'd0;
         out_shift_ff   <= 8'd0;
         read_accum_ff  <= 32'd0;
         format_ff      <= FMT_8;
         pins_ff        <= PINS_IDLE;
      end else if (advance) begin
         step_ff        <= step_in;
         bit_count_ff   <= bit_count_in;
         phase_count_ff <= phase_count_in;
         out_shift_ff   <= out_shift_in;
         read_accum_ff  <= read_accum_in;
         format_ff      <= format_in;
         pins_ff        <= pins_in;
      end
   end

   assign result.cs_n      = pins_in[PIN_CS];
   assign result.sclk      = pins_in[PIN_CLK];
   assign result.sdo       = pins_in[PIN_SDO];
   assign result.busy_res  = (step_in != S_IDLE);
   assign result.done_res  = done;
   assign result.read_data = read_accum_in;

endmodule

[sv/three_wire_9bit_spi_panel_master.sv]
// Top level of the three-wire 9-bit serial panel master.
//
// Each request transaction is either a tick of time (mode 0 or 3) or a
// command (mode 1 write, mode 2 read). Every request yields exactly one
// response transaction carrying the chip select, clock and data pin levels,
// busy and done flags, and the read accumulator. Ticks advance the pin
// sequence; a phase lasts ticks_per_phase ticks. Commands arriving during a
// transfer are dropped and do not count as ticks.
// A request passes an input register, then one pass of sequencer logic that
// updates the state and loads the response register. One request is
// accepted per cycle while the response receiver keeps up.
// When the response receiver stalls, the response register holds and the
// input register fills; req ready then falls until the response is taken.
// Synchronous reset empties both registers, returns the sequencer to idle
// with select high, clock and data low, and sets ticks_per_phase to 1.
// The phase length register sits at byte address 0 of the APB-style port;
// pready is always high and ticks_per_phase of 0 acts as 1.
module three_wire_9bit_spi_panel_master
   import twspi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   twspi_req_if.sink   req_ch,
   twspi_rsp_if.source rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic         advance;
   logic         req_take;
   logic [7:0]   ticks_per_phase;
   rsp_item_type seq_result;

   twspi_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .ticks_per_phase (ticks_per_phase)
   );

   twspi_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .item            (in_item_ff),
      .ticks_per_phase (ticks_per_phase),
      .result          (seq_result)
   );

   // The held request moves on when the response register is free or being taken.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in           = 1'b1;
         in_item_in.mode       = req_ch.mode;
         in_item_in.dc_flag    = req_ch.dc_flag;
         in_item_in.byte_value = req_ch.byte_value;
         in_item_in.sdi        = req_ch.sdi;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = seq_result;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control flags reset; payload registers simply follow.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.cs_n      = out_item_ff.cs_n;
   assign rsp_ch.sclk      = out_item_ff.sclk;
   assign rsp_ch.sdo       = out_item_ff.sdo;
   assign rsp_ch.busy_res  = out_item_ff.busy_res;
   assign rsp_ch.done_res  = out_item_ff.done_res;
   assign rsp_ch.read_data = out_item_ff.read_data;

endmodule
